>>> rtl/core/prod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prod_pkg;

  // Default sizes of the two run tables
  localparam int unsigned PROD_TABLE_ENTRIES = 64;
  localparam int unsigned PROD_COUNT_BITS    = 24;

  localparam int unsigned WAVE_W = 64;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned THR_W  = 24;
  localparam int unsigned IDX_W  = 2;

  // Wide enough to compare any run count against any threshold
  localparam int unsigned CMP_W  = 33;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1000000);

  typedef enum logic [IDX_W-1:0] {
    REG_SELF_WAVE   = 2'd0,
    REG_FWD_THRESH  = 2'd1,
    REG_REV_THRESH  = 2'd2,
    REG_UNUSED      = 2'd3
  } prod_reg_e;

  // Item travelling down the chain of cells, one cell per cycle
  typedef struct packed {
    logic              vld;
    logic [WAVE_W-1:0] wave;
    logic [POS_W-1:0]  pos;
    logic              f_done;
    logic              f_taken;
    logic              f_hit;
    logic              r_done;
    logic              r_taken;
    logic              r_hit;
  } prod_tok_t;

endpackage

`default_nettype wire

>>> rtl/core/prod_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module prod_cell import prod_pkg::*; #(
  parameter int unsigned CountBits = PROD_COUNT_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [THR_W-1:0] fwd_thr_i,
  input  wire logic [THR_W-1:0] rev_thr_i,
  input  wire prod_tok_t        tok_i,
  output prod_tok_t             tok_o
);

  // One forward entry and one reverse entry
  logic                 f_vld_q;
  logic [WAVE_W-1:0]    f_key_q;
  logic [POS_W-1:0]     f_last_q;
  logic [CountBits-1:0] f_cnt_q, f_cnt_d, f_inc;
  logic                 f_load, f_alloc;
  logic [POS_W-1:0]     f_next;

  logic                 r_vld_q;
  logic [WAVE_W-1:0]    r_key_q;
  logic [POS_W-1:0]     r_last_q;
  logic [CountBits-1:0] r_cnt_q, r_cnt_d, r_inc;
  logic                 r_load, r_alloc;
  logic [POS_W-1:0]     r_prev;

  prod_tok_t            tok_d, tok_q;

  assign f_next = f_last_q + POS_W'(1);
  assign r_prev = r_last_q - POS_W'(1);
  assign f_inc  = (f_cnt_q == '1) ? f_cnt_q : f_cnt_q + CountBits'(1);
  assign r_inc  = (r_cnt_q == '1) ? r_cnt_q : r_cnt_q + CountBits'(1);

  always_comb begin
    tok_d   = tok_i;
    f_load  = 1'b0;
    f_alloc = 1'b0;
    f_cnt_d = f_inc;
    r_load  = 1'b0;
    r_alloc = 1'b0;
    r_cnt_d = r_inc;

    // Forward: extend a known run by one, or open a new one at position zero
    if (tok_i.vld && !tok_i.f_done) begin
      if (f_vld_q) begin
        if (f_key_q == tok_i.wave) begin
          tok_d.f_done = 1'b1;
          if (tok_i.pos == f_next) begin
            f_load = 1'b1;
          end
        end
      end else begin
        tok_d.f_done = 1'b1;
        if (tok_i.pos == '0) begin
          f_alloc = 1'b1;
          f_cnt_d = CountBits'(1);
        end
      end
    end

    // Reverse: extend a known run downwards, or open a new one anywhere
    if (tok_i.vld && !tok_i.r_done) begin
      if (r_vld_q) begin
        if (r_key_q == tok_i.wave) begin
          tok_d.r_done = 1'b1;
          if (tok_i.pos == r_prev) begin
            r_load = 1'b1;
          end
        end
      end else begin
        tok_d.r_done = 1'b1;
        r_alloc      = 1'b1;
        r_cnt_d      = CountBits'(1);
      end
    end

    if (f_load || f_alloc) begin
      tok_d.f_taken = 1'b1;
      tok_d.f_hit   = CMP_W'(f_cnt_d) >= CMP_W'(fwd_thr_i);
    end
    if (r_load || r_alloc) begin
      tok_d.r_taken = 1'b1;
      tok_d.r_hit   = CMP_W'(r_cnt_d) >= CMP_W'(rev_thr_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
      r_vld_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      f_vld_q <= f_vld_q | f_alloc;
      r_vld_q <= r_vld_q | r_alloc;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_alloc) begin
      f_key_q <= tok_i.wave;
    end
    if (f_alloc || f_load) begin
      f_last_q <= tok_i.pos;
      f_cnt_q  <= f_cnt_d;
    end
    if (r_alloc) begin
      r_key_q <= tok_i.wave;
    end
    if (r_alloc || r_load) begin
      r_last_q <= tok_i.pos;
      r_cnt_q  <= r_cnt_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

>>> rtl/core/prod_exit.sv
`timescale 1ns / 1ps
`default_nettype none

module prod_exit import prod_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [WAVE_W-1:0] self_wave_i,
  input  wire prod_tok_t         tok_i,
  output logic                   out_valid_o,
  output logic                   alarm_o,
  output logic                   forward_taken_o,
  output logic                   reverse_taken_o,
  output logic                   dropped_full_o
);

  logic alarm_q, alarm_d;
  logic valid_q;
  logic f_taken_q, r_taken_q, full_q;
  logic f_full, r_full;

  // Reaching the end undecided means no free entry was found
  assign f_full = !tok_i.f_done && (tok_i.pos == '0);
  assign r_full = !tok_i.r_done;

  always_comb begin
    alarm_d = alarm_q;
    if (tok_i.vld) begin
      if (tok_i.f_hit || (tok_i.r_hit && (tok_i.wave > self_wave_i))) begin
        alarm_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      alarm_q <= alarm_d;
      valid_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    f_taken_q <= tok_i.f_taken;
    r_taken_q <= tok_i.r_taken;
    full_q    <= f_full | r_full;
  end

  assign out_valid_o     = valid_q;
  assign alarm_o         = alarm_q;
  assign forward_taken_o = f_taken_q;
  assign reverse_taken_o = r_taken_q;
  assign dropped_full_o  = full_q;

endmodule

`default_nettype wire

>>> rtl/core/path_run_overlap_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// Path run overlap detector.
// Command side: an observation (wave_i, progression_i) is taken at each rising
// edge with start_i high and busy_o low. busy_o stays low: the chain takes a
// new item every cycle, so throughput is one item per clock.
// Each item walks a chain of TableEntries cells, one cell per cycle; each cell
// holds one forward and one reverse table entry. Entries fill from cell 0 up
// and are never freed, so an item settles at its matching cell or at the first
// free one. Each result passes through the register of every cell and then the
// result register at the end of the chain.
// Results: out_valid_o strobes for one cycle per item with forward_taken_o,
// reverse_taken_o, dropped_full_o and the sticky alarm_o. The receiver cannot
// stall; results are never held back.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Write only while no item is in flight.
// Reset clears all valid bits and the alarm at once; no clearing pass.
module path_run_overlap_detector import prod_pkg::*; #(
  parameter int unsigned TableEntries = PROD_TABLE_ENTRIES,
  parameter int unsigned CountBits    = PROD_COUNT_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [WAVE_W-1:0]   wave_i,
  input  wire logic signed [POS_W-1:0] progression_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [IDX_W-1:0]    cfg_index_i,
  input  wire logic [WAVE_W-1:0]   cfg_data_i,
  output logic                     out_valid_o,
  output logic                     alarm_o,
  output logic                     forward_taken_o,
  output logic                     reverse_taken_o,
  output logic                     dropped_full_o
);

  logic [WAVE_W-1:0] self_wave_q;
  logic [THR_W-1:0]  fwd_thr_q;
  logic [THR_W-1:0]  rev_thr_q;
  logic              cfg_wr;

  prod_tok_t         launch_tok;
  prod_tok_t         tok [TableEntries+1];

  // The chain never backs up, so new items are always welcome
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // Hold configuration; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_wave_q <= '0;
      fwd_thr_q   <= THR_RESET;
      rev_thr_q   <= THR_RESET;
    end else if (cfg_wr) begin
      unique case (prod_reg_e'(cfg_index_i))
        REG_SELF_WAVE:  self_wave_q <= cfg_data_i;
        REG_FWD_THRESH: fwd_thr_q   <= cfg_data_i[THR_W-1:0];
        REG_REV_THRESH: rev_thr_q   <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Launch a fresh item into cell 0 with nothing decided yet
  always_comb begin
    launch_tok      = '0;
    launch_tok.vld  = start_i && !busy_o;
    launch_tok.wave = wave_i;
    launch_tok.pos  = progression_i;
  end

  assign tok[0] = launch_tok;

  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    prod_cell #(
      .CountBits (CountBits)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .fwd_thr_i (fwd_thr_q),
      .rev_thr_i (rev_thr_q),
      .tok_i     (tok[g]),
      .tok_o     (tok[g+1])
    );
  end

  // Settle flags and the sticky alarm once the item leaves the last cell
  prod_exit u_exit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .self_wave_i     (self_wave_q),
    .tok_i           (tok[TableEntries]),
    .out_valid_o     (out_valid_o),
    .alarm_o         (alarm_o),
    .forward_taken_o (forward_taken_o),
    .reverse_taken_o (reverse_taken_o),
    .dropped_full_o  (dropped_full_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/prod_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module prod_checker #(
  parameter int unsigned Latency = 65
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic out_valid_o,
  input wire logic alarm_o,
  input wire logic forward_taken_o,
  input wire logic reverse_taken_o,
  input wire logic dropped_full_o
);

  // Every item gets its result after the fixed chain latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency out_valid_o)
    else $error("result missing after chain latency");

  // Alarm stays set until reset
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_o |=> alarm_o)
    else $error("alarm cleared without reset");

  // Alarm only rises together with a result
  a_alarm_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(alarm_o) |-> out_valid_o)
    else $error("alarm rose without a result");

  // A table that dropped the item cannot also have taken it in both tables
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_full_o) |-> !(forward_taken_o && reverse_taken_o))
    else $error("drop flagged while both tables took the item");

endmodule

bind path_run_overlap_detector prod_checker #(
  .Latency (TableEntries + 1)
) u_prod_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .out_valid_o     (out_valid_o),
  .alarm_o         (alarm_o),
  .forward_taken_o (forward_taken_o),
  .reverse_taken_o (reverse_taken_o),
  .dropped_full_o  (dropped_full_o)
);

`default_nettype wire

>>> verif/path_run_overlap_detector_checker.sv
`timescale 1ns / 1ps

// Watches the command, configuration and result channels of the overlap
// detector, keeps its own copy of both run tables and flags any result
// that differs from what the tables say it should be.
module path_run_overlap_detector_checker import prod_pkg::*; #(
  parameter int unsigned Entries   = PROD_TABLE_ENTRIES,
  parameter int unsigned CountBits = PROD_COUNT_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     busy_i,
  input  wire logic [WAVE_W-1:0]        wave_i,
  input  wire logic signed [POS_W-1:0]  progression_i,
  input  wire logic                     cfg_valid_i,
  input  wire logic                     cfg_ready_i,
  input  wire logic [IDX_W-1:0]         cfg_index_i,
  input  wire logic [WAVE_W-1:0]        cfg_data_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     alarm_i,
  input  wire logic                     forward_taken_i,
  input  wire logic                     reverse_taken_i,
  input  wire logic                     dropped_full_i,
  output int                            pending_o,
  output int                            mismatch_count_o
);

  localparam int Forward = 0;
  localparam int Reverse = 1;
  localparam logic [CountBits-1:0] CountMax = '1;

  typedef struct packed {
    logic alarm;
    logic fwd_taken;
    logic rev_taken;
    logic full;
  } run_outcome_t;

  logic                 run_used [2][Entries];
  logic [WAVE_W-1:0]    run_id   [2][Entries];
  logic [POS_W-1:0]     run_last [2][Entries];
  logic [CountBits-1:0] run_len  [2][Entries];

  logic              alarm_seen;
  logic [WAVE_W-1:0] own_wave;
  logic [THR_W-1:0]  fwd_limit;
  logic [THR_W-1:0]  rev_limit;

  run_outcome_t outcome_q [$];
  int mismatches = 0;
  int outstanding = 0;
  int result_no = 0;

  assign pending_o        = outstanding;
  assign mismatch_count_o = mismatches;

  // Apply one observation to one table; hit an existing id first, else
  // allocate the lowest free entry if the rules allow it.
  task automatic apply_run(input int side, input logic [WAVE_W-1:0] id,
                           input logic [POS_W-1:0] pos, output logic taken,
                           output logic [CountBits-1:0] len, inout logic full);
    int hit;
    int slot;
    logic [POS_W-1:0] want;
    hit   = -1;
    slot  = -1;
    taken = 1'b0;
    len   = '0;
    for (int i = 0; i < Entries; i++) begin
      if (hit < 0 && run_used[side][i] && run_id[side][i] == id) hit = i;
    end
    if (hit >= 0) begin
      want = (side == Forward) ? run_last[side][hit] + 1'b1
                               : run_last[side][hit] - 1'b1;
      if (pos == want) begin
        taken = 1'b1;
        run_last[side][hit] = pos;
        if (run_len[side][hit] != CountMax) run_len[side][hit] += 1'b1;
        len = run_len[side][hit];
      end
    end else if (side == Reverse || pos == '0) begin
      for (int i = 0; i < Entries; i++) begin
        if (slot < 0 && !run_used[side][i]) slot = i;
      end
      if (slot < 0) begin
        full = 1'b1;
      end else begin
        run_used[side][slot] = 1'b1;
        run_id[side][slot]   = id;
        run_last[side][slot] = pos;
        run_len[side][slot]  = CountBits'(1);
        taken = 1'b1;
        len   = CountBits'(1);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    run_outcome_t got;
    run_outcome_t want;
    logic [CountBits-1:0] flen;
    logic [CountBits-1:0] rlen;
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < Entries; i++) run_used[s][i] = 1'b0;
      end
      alarm_seen = 1'b0;
      own_wave   = '0;
      fwd_limit  = THR_RESET;
      rev_limit  = THR_RESET;
      outcome_q.delete();
      outstanding = 0;
    end else begin
      if (out_valid_i) begin
        got = {alarm_i, forward_taken_i, reverse_taken_i, dropped_full_i};
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d with nothing outstanding: alarm=%b fwd=%b rev=%b full=%b",
                     result_no, got.alarm, got.fwd_taken, got.rev_taken, got.full);
        end else begin
          want = outcome_q.pop_front();
          if (got.alarm !== want.alarm || got.fwd_taken !== want.fwd_taken ||
              got.rev_taken !== want.rev_taken || got.full !== want.full) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d: expected alarm=%b fwd=%b rev=%b full=%b, ",
                        "got alarm=%b fwd=%b rev=%b full=%b"},
                       result_no, want.alarm, want.fwd_taken, want.rev_taken, want.full,
                       got.alarm, got.fwd_taken, got.rev_taken, got.full);
          end
        end
        result_no++;
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (prod_reg_e'(cfg_index_i))
          REG_SELF_WAVE:  own_wave  = cfg_data_i;
          REG_FWD_THRESH: fwd_limit = cfg_data_i[THR_W-1:0];
          REG_REV_THRESH: rev_limit = cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end

      if (start_i && !busy_i) begin
        want.full = 1'b0;
        apply_run(Forward, wave_i, progression_i, want.fwd_taken, flen, want.full);
        if (want.fwd_taken && CMP_W'(flen) >= CMP_W'(fwd_limit)) alarm_seen = 1'b1;
        apply_run(Reverse, wave_i, progression_i, want.rev_taken, rlen, want.full);
        if (want.rev_taken && CMP_W'(rlen) >= CMP_W'(rev_limit) && wave_i > own_wave)
          alarm_seen = 1'b1;
        want.alarm = alarm_seen;
        outcome_q = {outcome_q, want};
      end
      outstanding = outcome_q.size();
    end
  end

endmodule

>>> verif/path_run_overlap_detector_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the path run overlap detector. A checker beside
// the block predicts and compares every result; this module only feeds
// observations and register writes and decides pass or fail at the end.
module path_run_overlap_detector_tb;
  import prod_pkg::*;

  // Number of path ids that carry well-formed runs; the rest of the table
  // room is left for noise so that both tables end up full.
  localparam int unsigned PathCount  = 40;
  // Cycles with no handshake at all before the run is declared hung
  localparam int unsigned QuietLimit = 1000;
  // Roughly the pipeline depth plus margin
  localparam int unsigned TailCycles = 80;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [WAVE_W-1:0]        wave_i;
  logic signed [POS_W-1:0]  progression_i;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [IDX_W-1:0]         cfg_index_i;
  logic [WAVE_W-1:0]        cfg_data_i;
  logic                     out_valid_o;
  logic                     alarm_o;
  logic                     forward_taken_o;
  logic                     reverse_taken_o;
  logic                     dropped_full_o;

  int pending;
  int mismatch_count;
  int quiet_cycles = 0;
  bit steady;

  // Per path: its id and where the next in-order observation lies in each
  // direction, once a run has been opened.
  logic [WAVE_W-1:0] path_wave    [PathCount];
  logic [POS_W-1:0]  path_up      [PathCount];
  logic [POS_W-1:0]  path_down    [PathCount];
  bit                path_up_on   [PathCount];
  bit                path_down_on [PathCount];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  path_run_overlap_detector uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .wave_i          (wave_i),
    .progression_i   (progression_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .alarm_o         (alarm_o),
    .forward_taken_o (forward_taken_o),
    .reverse_taken_o (reverse_taken_o),
    .dropped_full_o  (dropped_full_o)
  );

  path_run_overlap_detector_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .wave_i           (wave_i),
    .progression_i    (progression_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_i      (out_valid_o),
    .alarm_i          (alarm_o),
    .forward_taken_i  (forward_taken_o),
    .reverse_taken_i  (reverse_taken_o),
    .dropped_full_i   (dropped_full_o),
    .pending_o        (pending),
    .mismatch_count_o (mismatch_count)
  );

  // Watchdog: any accepted item, result or register write resets the count.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || out_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one item from a falling edge; idle first at random unless in a
  // steady stretch. Hold start high afterwards so back-to-back items need
  // no second assignment in the same step.
  task automatic send_item(input logic [WAVE_W-1:0] w, input logic [POS_W-1:0] p);
    while (!steady && $urandom_range(99) < 34) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i       <= 1'b1;
    wave_i        <= w;
    progression_i <= p;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic drain_results();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Leave valid high; the caller drops it after the last write of a batch.
  task automatic write_reg(input prod_reg_e idx, input logic [WAVE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Mostly in-order runs on known paths, with some broken steps and some
  // noise that opens fresh ids until both tables are full.
  task automatic random_phase(input int count);
    int sent;
    int slot;
    int run_len;
    bit climb;
    bit broken;
    logic [POS_W-1:0] pos;
    sent = 0;
    while (sent < count) begin
      slot = $urandom_range(PathCount - 1);
      if ($urandom_range(99) < 22) begin
        case ($urandom_range(3))
          0:       send_item({$urandom, $urandom}, '0);
          1:       send_item({$urandom, $urandom}, $urandom);
          2:       send_item(path_wave[slot], $urandom);
          default: send_item(path_wave[slot], '0);
        endcase
        sent++;
      end else begin
        run_len = $urandom_range(1, 12);
        climb   = ($urandom_range(1) != 0);
        for (int k = 0; k < run_len && sent < count; k++) begin
          broken = ($urandom_range(99) < 8);
          if (climb) begin
            pos = path_up_on[slot] ? path_up[slot] : '0;
            if (broken) begin
              pos = pos + $urandom_range(2, 6);
            end else begin
              path_up_on[slot] = 1'b1;
              path_up[slot]    = pos + 1'b1;
            end
          end else begin
            if (path_down_on[slot]) begin
              pos = path_down[slot];
            end else begin
              // open near the extremes so some runs wrap from min to max
              case ($urandom_range(3))
                0:       pos = 32'h8000_0000 + $urandom_range(3);
                1:       pos = 32'h7FFF_FFFF - $urandom_range(3);
                2:       pos = $urandom_range(3);
                default: pos = $urandom;
              endcase
            end
            if (broken && path_down_on[slot]) begin
              pos = pos - $urandom_range(2, 6);
            end else begin
              path_down_on[slot] = 1'b1;
              path_down[slot]    = pos - 1'b1;
            end
          end
          send_item(path_wave[slot], pos);
          sent++;
        end
        if ($urandom_range(199) == 0) drain_results();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    wave_i        = '0;
    progression_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_SELF_WAVE;
    cfg_data_i    = '0;
    steady        = 1'b0;
    for (int i = 0; i < PathCount; i++) begin
      path_wave[i]    = {$urandom, $urandom};
      path_up_on[i]   = 1'b0;
      path_down_on[i] = 1'b0;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under reset settings: extreme ids and positions,
    // allocation in each table, in-order and out-of-order steps, and a
    // reverse run that wraps from the most negative position to the top.
    send_item('0, 32'd0);                          // open both tables
    send_item('0, 32'd1);                          // forward step, reverse refuses
    send_item('0, 32'hFFFF_FFFF);                  // reverse step down to -1
    send_item('1, 32'h8000_0000);                  // reverse only, no forward open
    send_item('1, 32'h7FFF_FFFF);                  // reverse wraps below minimum
    send_item('1, 32'd0);                          // forward opens at zero
    send_item('1, 32'd1);
    send_item({32{2'b01}}, 32'hFFFF_FFFF);
    send_item({32{2'b01}}, 32'hFFFF_FFFE);
    send_item({32{2'b10}}, 32'h7FFF_FFFF);         // reverse opens at maximum
    send_item({32{2'b10}}, 32'h7FFF_FFFE);
    send_item({32{2'b10}}, 32'd0);
    send_item({32{2'b10}}, 32'd5);                 // forward gap, refused
    send_item({32{2'b10}}, 32'd1);
    send_item('0, 32'd2);
    drain_results();

    // Reverse alarm cannot fire with own id at the top; forward limit out
    // of reach. The unused index must change nothing.
    write_reg(REG_SELF_WAVE, '1);
    write_reg(REG_FWD_THRESH, 64'hFF_FFFF);
    write_reg(REG_REV_THRESH, 64'd1);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    random_phase(280);
    drain_results();

    // Forward alarm reachable; junk above the threshold field must be masked.
    write_reg(REG_SELF_WAVE, '0);
    write_reg(REG_FWD_THRESH, {$urandom, 8'($urandom), 24'd30});
    write_reg(REG_REV_THRESH, 64'hFF_FFFF);
    cfg_valid_i <= 1'b0;
    steady = 1'b1;
    random_phase(150);
    steady = 1'b0;
    random_phase(130);
    drain_results();

    // Zero thresholds: every accepted observation meets them.
    write_reg(REG_FWD_THRESH, '0);
    write_reg(REG_REV_THRESH, '0);
    write_reg(REG_SELF_WAVE, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    random_phase(270);
    drain_results();

    write_reg(REG_SELF_WAVE, {$urandom, $urandom});
    write_reg(REG_FWD_THRESH, 64'd1000000);
    write_reg(REG_REV_THRESH, 64'd3);
    cfg_valid_i <= 1'b0;
    random_phase(270);

    drain_results();
    repeat (TailCycles) @(negedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
